// ===== design/wpbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions of the witness program bit regrouper.
package wpbr_pkg;

  localparam int MAX_PROGRAM_BYTES = 40;
  localparam int MAX_RESULTS       = 3;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [5:0] BYTE_SAT =
    (MAX_PROGRAM_BYTES < 63) ? 6'(MAX_PROGRAM_BYTES + 1) : 6'd63;
  localparam logic [5:0] MAX_BYTES = 6'(MAX_PROGRAM_BYTES);
  localparam logic [5:0] MIN_BYTES = 6'd2;
  localparam logic [5:0] V0_SHORT  = 6'd20;
  localparam logic [5:0] V0_LONG   = 6'd32;
  localparam logic [4:0] MAX_VER   = 5'd16;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_PADDING = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_V0_LENGTH   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_status;
    status_t    code;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    result_t [MAX_RESULTS-1:0]       res;
  } entry_t;

  function automatic logic [5:0] sat_inc(input logic [5:0] cnt);
    sat_inc = (cnt < BYTE_SAT) ? 6'(cnt + 6'd1) : cnt;
  endfunction

  function automatic status_t check_status(input logic [11:0] acc, input logic [2:0] pend,
                                           input logic [5:0] cnt, input logic [4:0] ver);
    logic [19:0] shifted;
    shifted = {8'd0, acc} << (4'd8 - {1'b0, pend});
    if (pend >= 3'd5 || shifted[7:0] != 8'd0) begin
      check_status = ST_BAD_PADDING;
    end else if (cnt < MIN_BYTES || cnt > MAX_BYTES) begin
      check_status = ST_BAD_LENGTH;
    end else if (ver > MAX_VER) begin
      check_status = ST_BAD_VERSION;
    end else if (ver == 5'd0 && cnt != V0_SHORT && cnt != V0_LONG) begin
      check_status = ST_V0_LENGTH;
    end else begin
      check_status = ST_OK;
    end
  endfunction

endpackage

// ===== design/wpbr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts words, regroups bits and builds the results of each word.
module wpbr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        item_value,
  input  logic              end_of_message,
  input  logic              queue_full,
  output logic              in_stall,
  output logic              push,
  output wpbr_pkg::entry_t  push_entry
);

  logic        pack_mode;
  logic [11:0] acc, acc_next;
  logic [2:0]  pend, pend_next;
  logic [5:0]  cnt, cnt_next;
  logic [4:0]  ver, ver_next;
  logic        start, start_next;
  logic        accept;

  wpbr_pkg::entry_t         ent;
  logic [wpbr_pkg::CNT_W-1:0] n;
  logic [3:0]                 bits;

  assign in_stall   = queue_full;
  assign accept     = in_valid && !queue_full;
  assign push       = accept && (ent.cnt != '0);
  assign push_entry = ent;

  always_comb begin
    acc_next   = acc;
    pend_next  = pend;
    cnt_next   = cnt;
    ver_next   = ver;
    start_next = start;
    n          = '0;
    ent        = '0;
    bits       = '0;
    if (start) begin
      acc_next   = '0;
      pend_next  = '0;
      cnt_next   = '0;
      ver_next   = item_value[4:0];
      start_next = 1'b0;
      if (pack_mode) begin
        ent.res[0].value = {3'd0, item_value[4:0]};
        n = wpbr_pkg::CNT_W'(1);
      end
    end else if (!pack_mode) begin
      bits     = {1'b0, pend} + 4'd5;
      acc_next = {acc[6:0], item_value[4:0]};
      if (bits >= 4'd8) begin
        bits             = bits - 4'd8;
        ent.res[0].value = 8'(acc_next >> bits);
        n                = wpbr_pkg::CNT_W'(1);
        cnt_next         = wpbr_pkg::sat_inc(cnt);
      end
      pend_next = bits[2:0];
    end else begin
      bits     = {1'b0, pend} + 4'd8;
      acc_next = {acc[3:0], item_value};
      cnt_next = wpbr_pkg::sat_inc(cnt);
      for (int i = 0; i < wpbr_pkg::MAX_RESULTS; i++) begin
        if (bits >= 4'd5) begin
          bits             = bits - 4'd5;
          ent.res[n].value = {3'd0, 5'(acc_next >> bits)};
          n                = n + 1'b1;
        end
      end
      pend_next = bits[2:0];
    end
    if (end_of_message) begin
      if (pack_mode) begin
        if (pend_next != 3'd0) begin
          ent.res[n].value = {3'd0, 5'(acc_next << (3'd5 - pend_next))};
          n                = n + 1'b1;
        end
      end else begin
        ent.res[n].is_status = 1'b1;
        ent.res[n].code      = wpbr_pkg::check_status(acc_next, pend_next, cnt_next, ver_next);
        n                    = n + 1'b1;
      end
      start_next = 1'b1;
    end
    ent.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_mode <= 1'b0;
      acc       <= '0;
      pend      <= '0;
      cnt       <= '0;
      ver       <= '0;
      start     <= 1'b1;
    end else if (cfg_write) begin
      pack_mode <= cfg_data;
      start     <= 1'b1;
    end else if (accept) begin
      acc   <= acc_next;
      pend  <= pend_next;
      cnt   <= cnt_next;
      ver   <= ver_next;
      start <= start_next;
    end
  end

endmodule

// ===== design/wpbr_queue.sv =====
`timescale 1ns / 1ps
// Short queue of result groups between the front and back ends.
module wpbr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wpbr_pkg::entry_t  push_entry,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output wpbr_pkg::entry_t  head
);

  localparam int PW = (wpbr_pkg::QUEUE_DEPTH > 1) ? $clog2(wpbr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(wpbr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(wpbr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(wpbr_pkg::QUEUE_DEPTH);

  wpbr_pkg::entry_t mem [wpbr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/wpbr_back.sv =====
`timescale 1ns / 1ps
// Back end: sends the results of each queued group one word at a time.
module wpbr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  wpbr_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_value,
  output logic              is_status,
  output logic [2:0]        status_code,
  output logic              last_result
);

  logic [wpbr_pkg::CNT_W-1:0] k;
  logic                       load;
  logic                       group_end;

  assign load      = head_valid && (!out_valid || !out_stall);
  assign group_end = (k == wpbr_pkg::CNT_W'(head.cnt - 1'b1));
  assign pop       = load && group_end;

  always_ff @(posedge clk) begin
    if (load) begin
      out_value   <= head.res[k].value;
      is_status   <= head.res[k].is_status;
      status_code <= head.res[k].code;
      last_result <= group_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        k         <= group_end ? '0 : k + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/witness_program_bit_regrouper.sv =====
`timescale 1ns / 1ps
// Top level of the witness program bit regrouper.
// The accepting edge writes a word's results into the queue; the output register then takes the first.
// Throughput: one word per cycle while each word gives at most one result and out_stall is low;
// otherwise the single output register sends the results one at a time (up to three in pack mode).
// Reset (rst, synchronous): unpack mode, next word starts a message, queue and output empty.
module witness_program_bit_regrouper (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] item_value,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic       is_status,
  output logic [2:0] status_code,
  output logic       last_result
);

  logic             queue_full;
  logic             push;
  logic             pop;
  logic             head_valid;
  wpbr_pkg::entry_t push_entry;
  wpbr_pkg::entry_t head;

  wpbr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .item_value     (item_value),
    .end_of_message (end_of_message),
    .queue_full     (queue_full),
    .in_stall       (in_stall),
    .push           (push),
    .push_entry     (push_entry)
  );

  wpbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  wpbr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .is_status   (is_status),
    .status_code (status_code),
    .last_result (last_result)
  );

endmodule

// ===== verif/regrouper_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and scores the output words of the witness program bit regrouper.
module regrouper_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] item_value,
  input  logic       end_of_message,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_value,
  input  logic       is_status,
  input  logic [2:0] status_code,
  input  logic       last_result,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [7:0]        value;
    logic              is_status;
    wpbr_pkg::status_t code;
    logic              last;
  } out_word_t;

  localparam logic [5:0] COUNT_CAP =
    (wpbr_pkg::MAX_PROGRAM_BYTES < 63) ? 6'(wpbr_pkg::MAX_PROGRAM_BYTES + 1) : 6'd63;

  logic        pack_mode;
  logic [11:0] acc;
  logic [2:0]  pend;
  logic [5:0]  nbytes;
  logic [4:0]  version;
  logic        msg_start;
  out_word_t   expected_words[$];

  function automatic wpbr_pkg::status_t grade_program(input logic [11:0] a,
                                                      input logic [2:0] p,
                                                      input logic [5:0] n,
                                                      input logic [4:0] v);
    logic [19:0] spill;
    spill = {8'd0, a} << (8 - int'(p));
    if (p >= 3'd5 || spill[7:0] != 8'd0) return wpbr_pkg::ST_BAD_PADDING;
    if (n < wpbr_pkg::MIN_BYTES || n > wpbr_pkg::MAX_BYTES) return wpbr_pkg::ST_BAD_LENGTH;
    if (v > wpbr_pkg::MAX_VER) return wpbr_pkg::ST_BAD_VERSION;
    if (v == 5'd0 && n != wpbr_pkg::V0_SHORT && n != wpbr_pkg::V0_LONG) begin
      return wpbr_pkg::ST_V0_LENGTH;
    end
    return wpbr_pkg::ST_OK;
  endfunction

  task automatic regroup_word(input logic [7:0] v, input logic eom);
    out_word_t   w [3];
    int          n;
    int          bits;
    int          i;
    logic [11:0] t;
    n = 0;
    if (msg_start) begin
      acc = '0;
      pend = '0;
      nbytes = '0;
      version = v[4:0];
      msg_start = 1'b0;
      if (pack_mode) begin
        w[n] = '{{3'd0, v[4:0]}, 1'b0, wpbr_pkg::ST_OK, 1'b0};
        n++;
      end
    end else if (!pack_mode) begin
      bits = int'(pend) + 5;
      acc = {acc[6:0], v[4:0]};
      if (bits >= 8) begin
        bits -= 8;
        w[n] = '{8'(acc >> bits), 1'b0, wpbr_pkg::ST_OK, 1'b0};
        n++;
        if (nbytes < COUNT_CAP) nbytes++;
      end
      pend = 3'(bits);
    end else begin
      bits = int'(pend) + 8;
      acc = {acc[3:0], v};
      if (nbytes < COUNT_CAP) nbytes++;
      while (bits >= 5) begin
        bits -= 5;
        t = acc >> bits;
        w[n] = '{{3'd0, t[4:0]}, 1'b0, wpbr_pkg::ST_OK, 1'b0};
        n++;
      end
      pend = 3'(bits);
    end
    if (eom) begin
      if (pack_mode) begin
        if (pend != 3'd0) begin
          // zero-pad the tail out to a whole symbol
          t = acc << (5 - int'(pend));
          w[n] = '{{3'd0, t[4:0]}, 1'b0, wpbr_pkg::ST_OK, 1'b0};
          n++;
        end
      end else begin
        w[n] = '{8'd0, 1'b1, grade_program(acc, pend, nbytes, version), 1'b0};
        n++;
      end
      msg_start = 1'b1;
    end
    if (n > 0) w[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_words = {expected_words, w[i]};
  endtask

  task automatic report_word(input string why, input out_word_t want);
    if (errors < 10) begin
      $display("%0t: %s: expected value=%02h status=%0b code=%0d last=%0b", $time, why,
               want.value, want.is_status, want.code, want.last);
      $display("%0t: %s: got      value=%02h status=%0b code=%0d last=%0b", $time, why,
               out_value, is_status, status_code, last_result);
    end
    errors++;
  endtask

  always @(posedge clk) begin : score
    out_word_t want;
    if (rst) begin
      pack_mode = 1'b0;
      acc = '0;
      pend = '0;
      nbytes = '0;
      version = '0;
      msg_start = 1'b1;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_word("unexpected word", '0);
        end else begin
          want = expected_words.pop_front();
          if (want.value !== out_value || want.is_status !== is_status ||
              want.code !== status_code || want.last !== last_result) begin
            report_word("mismatch", want);
          end
        end
      end
      if (cfg_write) begin
        pack_mode = cfg_data;
        msg_start = 1'b1;
      end
      if (in_valid && !in_stall) regroup_word(item_value, end_of_message);
    end
    pending = expected_words.size();
  end

endmodule

// ===== verif/witness_program_bit_regrouper_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the witness program bit regrouper: stimulus, idling and verdict.
module witness_program_bit_regrouper_tb;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] item_value = 8'd0;
  logic       end_of_message = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_value;
  logic       is_status;
  logic [2:0] status_code;
  logic       last_result;

  int check_errors;
  int words_pending;
  int idle_cycles = 0;
  int words_sent = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always #5 clk = ~clk;

  witness_program_bit_regrouper uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .item_value     (item_value),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .is_status      (is_status),
    .status_code    (status_code),
    .last_result    (last_result)
  );

  regrouper_checker regroup_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .item_value     (item_value),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .is_status      (is_status),
    .status_code    (status_code),
    .last_result    (last_result),
    .errors         (check_errors),
    .pending        (words_pending)
  );

  // hold the stall for a random run, mostly short
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!stalls_on || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_word(input logic [7:0] v, input logic eom);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    item_value <= v;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_outputs();
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // clean messages carry whole bytes with a zero pad; noisy ones are raw symbols
  task automatic send_unpack_message(input logic [7:0] ver, input int len, input bit clean,
                                     input bit finish);
    int         nsym;
    int         pad;
    int         i;
    logic [7:0] s;
    nsym = clean ? (len * 8 + 4) / 5 : len;
    pad = clean ? nsym * 5 - len * 8 : 0;
    send_word(ver, finish && nsym == 0);
    for (i = 0; i < nsym; i++) begin
      s = 8'($urandom);
      if (clean && i == nsym - 1) s = s & (8'hFF << pad);
      send_word(s, finish && i == nsym - 1);
    end
  endtask

  task automatic send_pack_message(input bit finish);
    int len;
    int i;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
    send_word(8'($urandom), finish && len == 0);
    for (i = 0; i < len; i++) send_word(8'($urandom), finish && i == len - 1);
  endtask

  initial begin : stimulus
    int phase;
    int nmsg;
    int k;
    int r;
    int first_word;
    bit mode;
    bit finish;
    bit long_done;
    long_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    // valid program, version 1, wide symbol
    send_word(8'h01, 1'b0);
    send_word(8'h1F, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h0A, 1'b0);
    send_word(8'h10, 1'b1);
    // empty program
    send_word(8'h05, 1'b1);
    // five leftover bits
    send_word(8'h02, 1'b0);
    send_word(8'h00, 1'b1);
    // nonzero leftover bits
    send_word(8'h03, 1'b0);
    send_word(8'h15, 1'b0);
    send_word(8'h03, 1'b1);
    // version 17 through a wide symbol
    send_word(8'hF1, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h1F, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    // version 0 with two bytes
    send_word(8'hE0, 1'b0);
    send_word(8'h15, 1'b0);
    send_word(8'h0A, 1'b0);
    send_word(8'h07, 1'b0);
    send_word(8'hE0, 1'b1);
    hold_input();
    drain_outputs();

    write_mode(1'b1);
    // wide version alone, then a byte that yields three symbols
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    hold_input();
    drain_outputs();

    phase = 0;
    first_word = words_sent;
    while (words_sent - first_word < RANDOM_WORDS) begin
      mode = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_mode(mode);
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      nmsg = $urandom_range(1, 4);
      for (k = 0; k < nmsg; k++) begin
        finish = (k < nmsg - 1) || ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 99);
        if (mode) begin
          send_pack_message(finish);
        end else if (!long_done) begin
          long_done = 1'b1;
          send_unpack_message({3'($urandom), 5'($urandom_range(1, 16))},
                              41 + $urandom_range(0, 4), 1'b1, 1'b1);
        end else if (r < 15) begin
          send_unpack_message({3'($urandom), 5'd0}, ($urandom_range(0, 3) == 0) ? 32 : 20,
                              1'b1, finish);
        end else if (r < 60) begin
          send_unpack_message({3'($urandom), 5'($urandom_range(1, 16))},
                              $urandom_range(2, 8), 1'b1, finish);
        end else if (r < 85) begin
          send_unpack_message(8'($urandom), $urandom_range(0, 12), 1'b1, finish);
        end else begin
          send_unpack_message(8'($urandom), $urandom_range(0, 10), 1'b0, finish);
        end
        if ((phase == 0 && k == 0) || $urandom_range(0, 5) == 0) begin
          hold_input();
          drain_outputs();
        end
      end
      hold_input();
      drain_outputs();
      phase++;
    end

    if (check_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/wpbr_pkg.sv
design/wpbr_front.sv
design/wpbr_queue.sv
design/wpbr_back.sv
design/witness_program_bit_regrouper.sv
verif/regrouper_checker.sv
verif/witness_program_bit_regrouper_tb.sv
